// ===== src/oeq_pkg.sv =====
// Shared types and command codes for the overwrite event queue.
package oeq_pkg;

    localparam int DEF_SLOT_COUNT = 64;

    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic [15:0] marks;
        logic [15:0] code;
        logic [15:0] source;
        logic [7:0]  kind;
    } t_header;

    typedef struct packed {
        t_header     header;
        logic [63:0] payload;
        logic [31:0] seq_num;
    } t_slot;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

    typedef struct packed {
        logic        status;
        logic        pop_hit;
        logic [31:0] seq_num;
        logic [6:0]  fill;
        logic [31:0] drop;
        logic [31:0] last;
    } t_stage_info;

endpackage

// ===== src/oeq_store.sv =====
// Slot memory: one write port and one registered read port.
module oeq_store #(
    parameter int SLOT_COUNT = oeq_pkg::DEF_SLOT_COUNT,
    localparam int IDX_W = $clog2(SLOT_COUNT)
) (
    input  logic               i_clk,
    input  oeq_pkg::t_mem_ctl  i_mem_ctl,
    input  logic [IDX_W-1:0]   i_wr_addr,
    input  logic [IDX_W-1:0]   i_rd_addr,
    input  oeq_pkg::t_slot     i_wr_data,
    output oeq_pkg::t_slot     o_rd_data
);
    import oeq_pkg::*;

    t_slot r_mem [SLOT_COUNT];
    t_slot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_mem_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_mem_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/oeq_ctrl.sv =====
// Queue pointers, counters and per-command bookkeeping.
module oeq_ctrl #(
    parameter int SLOT_COUNT = oeq_pkg::DEF_SLOT_COUNT,
    localparam int IDX_W = $clog2(SLOT_COUNT)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [1:0]            i_command,
    output oeq_pkg::t_mem_ctl     o_mem_ctl,
    output logic [IDX_W-1:0]      o_wr_addr,
    output logic [IDX_W-1:0]      o_rd_addr,
    output oeq_pkg::t_stage_info  o_info
);
    import oeq_pkg::*;

    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOT_COUNT - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(SLOT_COUNT);

    logic [IDX_W-1:0] r_wr_idx, n_wr_idx;
    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;
    logic [CNT_W-1:0] r_count, n_count;
    logic [31:0]      r_drop, n_drop;
    logic [31:0]      r_seq, n_seq;
    t_stage_info      r_info, n_info;
    t_mem_ctl         mem_ctl;
    logic             status;
    logic             pop_hit;
    logic [31:0]      seq_out;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    always_comb begin
        n_wr_idx = r_wr_idx;
        n_rd_idx = r_rd_idx;
        n_count  = r_count;
        n_drop   = r_drop;
        n_seq    = r_seq;
        mem_ctl  = '0;
        status   = 1'b0;
        pop_hit  = 1'b0;
        seq_out  = '0;
        if (i_accept) begin
            unique case (i_command)
                CMD_PUSH: begin
                    // full: drop the oldest word, count stays at depth
                    if (r_count == FULL_CNT) begin
                        n_rd_idx = next_idx(r_rd_idx);
                        n_drop   = r_drop + 32'd1;
                    end else begin
                        n_count  = r_count + 1'b1;
                    end
                    n_seq         = r_seq + 32'd1;
                    seq_out       = n_seq;
                    n_wr_idx      = next_idx(r_wr_idx);
                    mem_ctl.wr_en = 1'b1;
                end
                CMD_POP: begin
                    if (r_count == '0) begin
                        status = 1'b1;
                    end else begin
                        pop_hit       = 1'b1;
                        mem_ctl.rd_en = 1'b1;
                        n_rd_idx      = next_idx(r_rd_idx);
                        n_count       = r_count - 1'b1;
                    end
                end
                CMD_CLEAR: begin
                    n_wr_idx = '0;
                    n_rd_idx = '0;
                    n_count  = '0;
                end
                default: begin
                end
            endcase
        end
        n_info.status  = status;
        n_info.pop_hit = pop_hit;
        n_info.seq_num = seq_out;
        n_info.fill    = 7'(n_count);
        n_info.drop    = n_drop;
        n_info.last    = n_seq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_count  <= '0;
            r_drop   <= '0;
            r_seq    <= '0;
        end else begin
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
            r_count  <= n_count;
            r_drop   <= n_drop;
            r_seq    <= n_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_info <= n_info;
        end
    end

    assign o_mem_ctl = mem_ctl;
    assign o_wr_addr = r_wr_idx;
    assign o_rd_addr = r_rd_idx;
    assign o_info    = r_info;

endmodule

// ===== src/overwrite_event_queue.sv =====
// Overwrite event queue top level: slot memory, control and result register.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------------
//  in      | input     | i_in_valid / o_in_stall | command and pushed event fields
//  out     | output    | o_out_valid / i_out_stall | status, popped event, counters
//
//  One word per cycle sustained while the output is not stalled.
//  The first stage updates pointers and counters and issues the slot memory access,
//  the second captures the memory read data into the result register.
//  Reset (synchronous, active low) empties the queue and zeroes both counters.
//  A stalled result holds; the input stalls only when both stages are occupied.
module overwrite_event_queue #(
    parameter int SLOT_COUNT = oeq_pkg::DEF_SLOT_COUNT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_event_kind,
    input  logic [15:0] i_source_id,
    input  logic [15:0] i_event_code,
    input  logic [15:0] i_event_marks,
    input  logic [63:0] i_event_payload,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_result_status,
    output logic [7:0]  o_out_kind,
    output logic [15:0] o_out_source,
    output logic [15:0] o_out_code,
    output logic [15:0] o_out_marks,
    output logic [63:0] o_out_payload,
    output logic [31:0] o_out_sequence,
    output logic [6:0]  o_fill_level,
    output logic [31:0] o_drop_total,
    output logic [31:0] o_last_sequence
);
    import oeq_pkg::*;

    localparam int IDX_W = $clog2(SLOT_COUNT);

    logic             accept;
    logic             s1_adv;
    logic             r_s1_valid;
    logic             r_out_valid;
    t_mem_ctl         mem_ctl;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    t_slot            wr_data;
    t_slot            rd_data;
    t_stage_info      info;
    logic [31:0]      info_seq_next;
    logic [31:0]      r_seq_cnt;

    logic             r_status;
    t_header          r_header;
    logic [63:0]      r_payload;
    logic [31:0]      r_seq_num;
    logic [6:0]       r_fill;
    logic [31:0]      r_drop;
    logic [31:0]      r_last;

    assign s1_adv     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign accept     = i_in_valid && !o_in_stall;

    assign wr_data.header.kind   = i_event_kind;
    assign wr_data.header.source = i_source_id;
    assign wr_data.header.code   = i_event_code;
    assign wr_data.header.marks  = i_event_marks;
    assign wr_data.payload       = i_event_payload;
    assign wr_data.seq_num       = info_seq_next;

    // sequence stamped on a push: counter value after increment
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_cnt <= '0;
        end else if (mem_ctl.wr_en) begin
            r_seq_cnt <= info_seq_next;
        end
    end
    assign info_seq_next = r_seq_cnt + 32'd1;

    oeq_ctrl #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_command (i_command),
        .o_mem_ctl (mem_ctl),
        .o_wr_addr (wr_addr),
        .o_rd_addr (rd_addr),
        .o_info    (info)
    );

    oeq_store #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_store (
        .i_clk     (i_clk),
        .i_mem_ctl (mem_ctl),
        .i_wr_addr (wr_addr),
        .i_rd_addr (rd_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // event header and payload read as zero unless a pop found an entry
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_status  <= info.status;
            r_header  <= info.pop_hit ? rd_data.header : '0;
            r_payload <= info.pop_hit ? rd_data.payload : '0;
            r_seq_num <= info.pop_hit ? rd_data.seq_num : info.seq_num;
            r_fill    <= info.fill;
            r_drop    <= info.drop;
            r_last    <= info.last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_status = r_status;
    assign o_out_kind      = r_header.kind;
    assign o_out_source    = r_header.source;
    assign o_out_code      = r_header.code;
    assign o_out_marks     = r_header.marks;
    assign o_out_payload   = r_payload;
    assign o_out_sequence  = r_seq_num;
    assign o_fill_level    = r_fill;
    assign o_drop_total    = r_drop;
    assign o_last_sequence = r_last;

endmodule

// ===== src/oeq_checker.sv =====
// Port-level checks for the overwrite event queue, bound to the top level.
module oeq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_result_status,
    input logic [7:0]  o_out_kind,
    input logic [63:0] o_out_payload,
    input logic [31:0] o_out_sequence,
    input logic [6:0]  o_fill_level,
    input logic [31:0] o_last_sequence
);

    // an empty pop carries no event and reports an empty queue
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_status |->
            o_out_kind == 8'd0 && o_out_payload == 64'd0 &&
            o_out_sequence == 32'd0 && o_fill_level == 7'd0)
        else $error("empty pop result carries data or nonzero fill");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_sequence) && $stable(o_last_sequence))
        else $error("stalled result changed");

    // last sequence moves by at most one between consecutive results
    a_seq_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall ##1 o_out_valid |->
            o_last_sequence == $past(o_last_sequence) ||
            o_last_sequence == $past(o_last_sequence) + 32'd1)
        else $error("last sequence jumped");

endmodule

bind overwrite_event_queue oeq_checker u_oeq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_result_status (o_result_status),
    .o_out_kind      (o_out_kind),
    .o_out_payload   (o_out_payload),
    .o_out_sequence  (o_out_sequence),
    .o_fill_level    (o_fill_level),
    .o_last_sequence (o_last_sequence)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the overwrite event queue: mirror model, stimulus, result checks.
module tb_top;
    import oeq_pkg::*;

    localparam int DEPTH       = DEF_SLOT_COUNT;
    localparam int WORD_COUNT  = 1700;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT  = 4000;
    localparam int SHOW_LIMIT  = 50;

    // the one command value that the queue ignores
    localparam logic [1:0] CMD_NONE = 2'd3;

    typedef enum int {
        MIX_FLOOD,
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } t_mix;

    typedef struct packed {
        logic        status;
        t_header     hdr;
        logic [63:0] payload;
        logic [31:0] seq_num;
        logic [6:0]  fill;
        logic [31:0] drop;
        logic [31:0] last;
    } t_result;

    // Mirror of the ring: predicts one result per accepted word and checks them in order.
    class queue_mirror;
        t_slot       slots [DEPTH];
        int unsigned wr_idx;
        int unsigned rd_idx;
        int unsigned held;
        logic [31:0] drops;
        logic [31:0] seq_ctr;
        t_result     pending_results [$];
        int unsigned errors;

        function new();
            wr_idx  = 0;
            rd_idx  = 0;
            held    = 0;
            drops   = '0;
            seq_ctr = '0;
            errors  = 0;
        endfunction

        function void note_word(logic [1:0] cmd, t_header hdr, logic [63:0] pay);
            t_result want;
            want = '0;
            case (cmd)
                CMD_PUSH: begin
                    // full: drop the oldest entry before storing
                    if (held == DEPTH) begin
                        rd_idx = (rd_idx + 1) % DEPTH;
                        held   = held - 1;
                        drops  = drops + 32'd1;
                    end
                    seq_ctr                = seq_ctr + 32'd1;
                    slots[wr_idx].header   = hdr;
                    slots[wr_idx].payload  = pay;
                    slots[wr_idx].seq_num  = seq_ctr;
                    wr_idx                 = (wr_idx + 1) % DEPTH;
                    held                   = held + 1;
                    want.seq_num           = seq_ctr;
                end
                CMD_POP: begin
                    if (held == 0) begin
                        want.status = 1'b1;
                    end else begin
                        want.hdr     = slots[rd_idx].header;
                        want.payload = slots[rd_idx].payload;
                        want.seq_num = slots[rd_idx].seq_num;
                        rd_idx       = (rd_idx + 1) % DEPTH;
                        held         = held - 1;
                    end
                end
                CMD_CLEAR: begin
                    wr_idx = 0;
                    rd_idx = 0;
                    held   = 0;
                end
                default: begin
                end
            endcase
            want.fill = held[6:0];
            want.drop = drops;
            want.last = seq_ctr;
            pending_results.push_back(want);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
                             want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $display("%0t: result with nothing pending, expected none, actual %0h",
                             $time, got);
                return;
            end
            want = pending_results.pop_front();
            compare_field("result_status", 64'(want.status), 64'(got.status));
            compare_field("out_kind", 64'(want.hdr.kind), 64'(got.hdr.kind));
            compare_field("out_source", 64'(want.hdr.source), 64'(got.hdr.source));
            compare_field("out_code", 64'(want.hdr.code), 64'(got.hdr.code));
            compare_field("out_marks", 64'(want.hdr.marks), 64'(got.hdr.marks));
            compare_field("out_payload", want.payload, got.payload);
            compare_field("out_sequence", 64'(want.seq_num), 64'(got.seq_num));
            compare_field("fill_level", 64'(want.fill), 64'(got.fill));
            compare_field("drop_total", 64'(want.drop), 64'(got.drop));
            compare_field("last_sequence", 64'(want.last), 64'(got.last));
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_command;
    logic [7:0]  i_event_kind;
    logic [15:0] i_source_id;
    logic [15:0] i_event_code;
    logic [15:0] i_event_marks;
    logic [63:0] i_event_payload;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_result_status;
    logic [7:0]  o_out_kind;
    logic [15:0] o_out_source;
    logic [15:0] o_out_code;
    logic [15:0] o_out_marks;
    logic [63:0] o_out_payload;
    logic [31:0] o_out_sequence;
    logic [6:0]  o_fill_level;
    logic [31:0] o_drop_total;
    logic [31:0] o_last_sequence;

    queue_mirror mirror = new();
    bit          pressure_go = 1'b0;
    int unsigned burst_left = 0;
    int unsigned idle_cycles = 0;

    overwrite_event_queue #(
        .SLOT_COUNT(DEPTH)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_event_kind    (i_event_kind),
        .i_source_id     (i_source_id),
        .i_event_code    (i_event_code),
        .i_event_marks   (i_event_marks),
        .i_event_payload (i_event_payload),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_result_status (o_result_status),
        .o_out_kind      (o_out_kind),
        .o_out_source    (o_out_source),
        .o_out_code      (o_out_code),
        .o_out_marks     (o_out_marks),
        .o_out_payload   (o_out_payload),
        .o_out_sequence  (o_out_sequence),
        .o_fill_level    (o_fill_level),
        .o_drop_total    (o_drop_total),
        .o_last_sequence (o_last_sequence)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // random word with a bias toward all zeros and all ones
    function automatic logic [63:0] rand_word();
        logic [63:0] v;
        int unsigned pick;
        pick = $urandom_range(0, 15);
        v    = {$urandom, $urandom};
        if (pick == 0)
            v = '0;
        else if (pick == 1)
            v = '1;
        return v;
    endfunction

    task automatic make_word(t_mix mix, output logic [1:0] cmd, output t_header hdr,
                             output logic [63:0] pay);
        int unsigned roll;
        int unsigned push_top;
        logic [63:0] w;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  push_top = 84;
            MIX_DRAIN: push_top = 24;
            default:   push_top = 52;
        endcase
        if (mix == MIX_FLOOD)
            cmd = CMD_PUSH;
        else if (roll < 2)
            cmd = CMD_CLEAR;
        else if (roll < 4)
            cmd = CMD_NONE;
        else if (roll < push_top)
            cmd = CMD_PUSH;
        else
            cmd = CMD_POP;
        w          = rand_word();
        hdr.kind   = w[7:0];
        w          = rand_word();
        hdr.source = w[15:0];
        w          = rand_word();
        hdr.code   = w[15:0];
        w          = rand_word();
        hdr.marks  = w[15:0];
        pay        = rand_word();
    endtask

    // offer one word in bursts with random gaps; hold it until taken
    task automatic send_word(logic [1:0] cmd, t_header hdr, logic [63:0] pay);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid      <= 1'b1;
        i_command       <= cmd;
        i_event_kind    <= hdr.kind;
        i_source_id     <= hdr.source;
        i_event_code    <= hdr.code;
        i_event_marks   <= hdr.marks;
        i_event_payload <= pay;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        mirror.note_word(cmd, hdr, pay);
    endtask

    task automatic send_random(t_mix mix);
        logic [1:0]  cmd;
        t_header     hdr;
        logic [63:0] pay;
        make_word(mix, cmd, hdr, pay);
        send_word(cmd, hdr, pay);
    endtask

    // stimulus
    initial begin
        int unsigned sent;
        int unsigned seg_len;
        t_mix        mix;
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_command       <= CMD_PUSH;
        i_event_kind    <= '0;
        i_source_id     <= '0;
        i_event_code    <= '0;
        i_event_marks   <= '0;
        i_event_payload <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty pops, extreme events, ignored command, clears
        send_word(CMD_POP, '0, '0);
        send_word(CMD_PUSH, '0, '0);
        send_word(CMD_PUSH, '1, '1);
        send_random(MIX_FLOOD);
        send_word(CMD_NONE, '1, '1);
        send_word(CMD_POP, '0, '0);
        send_word(CMD_POP, '1, '1);
        send_word(CMD_POP, '0, '0);
        send_word(CMD_POP, '0, '0);
        send_word(CMD_CLEAR, '0, '0);
        send_random(MIX_FLOOD);
        send_random(MIX_FLOOD);
        send_word(CMD_CLEAR, '1, '1);
        send_word(CMD_POP, '0, '0);
        send_random(MIX_FLOOD);
        send_word(CMD_POP, '0, '0);
        sent = 16;

        // flood past full, starting while the output is held off
        pressure_go = 1'b1;
        for (int k = 0; k < 100; k++)
            send_random(MIX_FLOOD);
        sent += 100;

        while (sent < WORD_COUNT) begin
            seg_len = $urandom_range(20, 150);
            case ($urandom_range(0, 2))
                0:       mix = MIX_FILL;
                1:       mix = MIX_DRAIN;
                default: mix = MIX_EVEN;
            endcase
            for (int k = 0; k < seg_len && sent < WORD_COUNT; k++) begin
                send_random(mix);
                sent++;
            end
        end
        i_in_valid <= 1'b0;

        while (mirror.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mirror.errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // receiver: stall patterns that change block by block, with one long hold-off when the flood starts
    initial begin
        int unsigned hold_left;
        int unsigned blk_left;
        int unsigned mode;
        bit          held_off;
        hold_left   = 0;
        blk_left    = 0;
        mode        = 0;
        held_off    = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (pressure_go && !held_off) begin
                held_off  = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (blk_left == 0) begin
                mode     = $urandom_range(0, 3);
                blk_left = $urandom_range(16, 96);
            end
            blk_left--;
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 9) < 3);
                    2:       i_out_stall <= ($urandom_range(0, 9) < 7);
                    default: i_out_stall <= (blk_left % 5 == 0);
                endcase
            end
        end
    end

    // check every result taken
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.status     = o_result_status;
            got.hdr.kind   = o_out_kind;
            got.hdr.source = o_out_source;
            got.hdr.code   = o_out_code;
            got.hdr.marks  = o_out_marks;
            got.payload    = o_out_payload;
            got.seq_num    = o_out_sequence;
            got.fill       = o_fill_level;
            got.drop       = o_drop_total;
            got.last       = o_last_sequence;
            mirror.check_result(got);
        end
    end

    // end the run when neither channel moves a word for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
            $display("tb_top NOT OK");
            $finish;
        end
    end

endmodule
